// ----- sv/cfvs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the coordinate queue with visited search.
// No dependencies; every other file of the block imports this package.
package cfvs_pkg;

    localparam int DEPTH      = 1024;
    localparam int COORD_BITS = 8;
    localparam int ENTRY_W    = 2 * COORD_BITS;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int S_DATA_W   = ENTRY_W;
    localparam int S_USER_W   = 2;
    localparam int M_FIELDS_W = 5 + 2 * COORD_BITS;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [S_USER_W-1:0] CMD_ENQUEUE  = 2'd0;
    localparam logic [S_USER_W-1:0] CMD_DEQUEUE  = 2'd1;
    localparam logic [S_USER_W-1:0] CMD_CONTAINS = 2'd2;
    localparam logic [S_USER_W-1:0] CMD_CLEAR    = 2'd3;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [CNT_W-1:0]   remain;
        logic [ENTRY_W-1:0] key;
    } search_tok_t;

endpackage

// ----- sv/cfvs_cell.sv -----
`timescale 1ns / 1ps
// One cell of the search chain: holds one queue entry and compares the passing token.
// Depends on cfvs_pkg.
module cfvs_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [cfvs_pkg::ENTRY_W-1:0]  wr_data,
    input  cfvs_pkg::search_tok_t         tok_in,
    output cfvs_pkg::search_tok_t         tok_out
);
    import cfvs_pkg::*;

    logic [ENTRY_W-1:0] entry_reg;
    logic               valid_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic [ENTRY_W-1:0] key_reg;
    logic               live;
    logic               hit;

    assign live = (tok_in.remain != '0);
    assign hit  = live && (entry_reg == tok_in.key);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    // advance the token one cell per cycle
    always_ff @(posedge clk)
    begin
        found_reg  <= tok_in.found | hit;
        remain_reg <= live ? tok_in.remain - CNT_W'(1) : tok_in.remain;
        key_reg    <= tok_in.key;
    end

    always_comb
    begin
        tok_out.valid  = valid_reg;
        tok_out.found  = found_reg;
        tok_out.remain = remain_reg;
        tok_out.key    = key_reg;
    end

endmodule

// ----- sv/cfvs_chain.sv -----
`timescale 1ns / 1ps
// Row of DEPTH search cells, one per queue slot, with the slot write decode.
// Depends on cfvs_pkg and cfvs_cell.
module cfvs_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [cfvs_pkg::IDX_W-1:0]    wr_idx,
    input  logic [cfvs_pkg::ENTRY_W-1:0]  wr_data,
    input  cfvs_pkg::search_tok_t         tok_in,
    output cfvs_pkg::search_tok_t         tok_out
);
    import cfvs_pkg::*;

    search_tok_t tok [DEPTH+1];

    assign tok[0]  = tok_in;
    assign tok_out = tok[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cfvs_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr_en   (wr_en && (wr_idx == IDX_W'(i))),
                .wr_data (wr_data),
                .tok_in  (tok[i]),
                .tok_out (tok[i+1])
            );
        end
    endgenerate

endmodule

// ----- sv/coordinate_fifo_with_visited_search.sv -----
`timescale 1ns / 1ps
// Coordinate queue for a breadth-first flood, with a search over removed entries.
// Depends on cfvs_pkg and cfvs_chain.
//
// Usage:
//   Commands arrive on the s_ stream: s_tuser selects enqueue, dequeue, contains
//   or clear, s_tdata carries the (x, y) pair. Each command yields exactly one
//   result transfer on the m_ stream with found, rejected, empty and full flags
//   and the front entry of the queue (zero with head_valid low when empty).
//   The store is linear and never wraps; clear returns both indices to zero.
//   Enqueue, dequeue and clear pass through the read and output states before
//   m_tvalid rises; contains first waits in the scan state for the search token
//   that walks the chain of DEPTH cells one cell per cycle. One command is in
//   work at a time; s_tready is high only while the block waits for a command,
//   so a new command is taken only once the last result is in the output register.
//   A finished result sits in the output register, so the next command is
//   taken while m_tready is low; a second result waits until the first leaves.
//   Reset empties the queue and the output register; stored entries are not
//   cleared and are never used before they are written.
module coordinate_fifo_with_visited_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cfvs_pkg::S_DATA_W-1:0]  s_tdata,   // cell_x, cell_y
    input  logic [cfvs_pkg::S_USER_W-1:0]  s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cfvs_pkg::M_DATA_W-1:0]  m_tdata    // found, rejected, is_empty,
                                                      // is_full, head_valid, head_y,
                                                      // head_x, zero fill
);
    import cfvs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic                rej_reg, rej_next;
    logic                found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [ENTRY_W-1:0]  rd_reg;
    logic [ENTRY_W-1:0]  mem [DEPTH];
    logic                mem_we;
    logic                q_full;
    logic                q_empty;
    logic                head_valid;
    logic [ENTRY_W-1:0]  head_entry;
    search_tok_t         tok_in;
    search_tok_t         tok_out;

    assign q_full     = (tail_reg == CNT_W'(DEPTH));
    assign q_empty    = (removed_reg == tail_reg);
    assign head_valid = (removed_reg < tail_reg);
    assign head_entry = head_valid ? rd_reg : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        removed_next = removed_reg;
        tail_next    = tail_reg;
        rej_next     = rej_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        tok_in.valid  = 1'b0;
        tok_in.found  = 1'b0;
        tok_in.remain = removed_reg;
        tok_in.key    = s_tdata[ENTRY_W-1:0];

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rej_next   = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_READ;
                    case (s_tuser)
                        CMD_ENQUEUE:
                        begin
                            if (q_full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = tail_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (q_empty)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                removed_next = removed_reg + CNT_W'(1);
                            end
                        end
                        CMD_CONTAINS:
                        begin
                            tok_in.valid = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            removed_next = '0;
                            tail_next    = '0;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (tok_out.valid)
                begin
                    found_next = tok_out.found;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({head_entry[ENTRY_W-1:COORD_BITS],
                                              head_entry[COORD_BITS-1:0],
                                              head_valid, q_full, q_empty,
                                              rej_reg, found_reg});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            removed_reg <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            removed_reg <= removed_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rej_reg    <= rej_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg[IDX_W-1:0]] <= s_tdata[ENTRY_W-1:0];
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[removed_reg[IDX_W-1:0]];
        end
    end

    cfvs_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_idx  (tail_reg[IDX_W-1:0]),
        .wr_data (s_tdata[ENTRY_W-1:0]),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    a_head_behind_tail: assert property (@(posedge clk) disable iff (!rst_n)
        removed_reg <= tail_reg)
        else $error("removed count passed tail index");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= CNT_W'(DEPTH))
        else $error("tail index beyond depth");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid |-> (state_reg == ST_SCAN))
        else $error("search token left the chain outside a scan");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");

endmodule
